>>> sv/rnn_sequence_inference_top_assert.svh
// Assertion macros shared by the checker of the inference block.
`ifndef RNN_SEQUENCE_INFERENCE_TOP_ASSERT_SVH
`define RNN_SEQUENCE_INFERENCE_TOP_ASSERT_SVH
// Same-cycle implication, off during reset.
`define RSI_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rsi assertion failed");
// Next-cycle implication, off during reset.
`define RSI_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rsi assertion failed");
// Next-cycle implication that also holds while reset is high.
`define RSI_ASSERT_RST(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("rsi assertion failed");
`endif

>>> sv/rsi_pkg.sv
`default_nettype none
package rsi_pkg;
   localparam int HIDDEN_DEF  = 32;
   localparam int INPUTS_DEF  = 6;
   localparam int OUTPUTS_DEF = 4;
   localparam int SAMPLES_DEF = 32;
   localparam int QDEPTH      = 2;
   localparam int ACC_W       = 48;
   localparam int X_W         = ACC_W - 12;

   localparam logic [1:0] CMD_WLOAD = 2'd0;
   localparam logic [1:0] CMD_SLOAD = 2'd1;
   localparam logic [1:0] CMD_RUN   = 2'd2;

   typedef enum logic [1:0] {KIND_WLOAD, KIND_SLOAD, KIND_RUN} kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [10:0]        address;
      logic signed [15:0] value;
      logic [4:0]         start_sample;
   } item_type;

   typedef struct packed {
      logic     vld;
      item_type item;
   } head_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_PREP, BK_MAC, BK_DRAIN, BK_ACT, BK_OUT
   } back_state_type;

   typedef enum logic [3:0] {
      SE_IDLE, SE_POS, SE_M2, SE_M3, SE_DIV, SE_SUM, SE_SQ, SE_FIN, SE_NEG, SE_DONE
   } selu_state_type;

   typedef enum logic [1:0] {SRC_ZERO, SRC_SMP, SRC_HID, SRC_BIAS} src_type;

   typedef struct packed {
      logic                  start;
      logic signed [X_W-1:0] x;
   } selu_req_type;

   typedef struct packed {
      logic               done;
      logic signed [15:0] y;
   } selu_rsp_type;

   function automatic int weight_depth(int h, int i, int o);
      return i * h + h * h + h + h * o + o;
   endfunction

   function automatic logic signed [15:0] sat16(logic signed [X_W-1:0] v);
      logic signed [15:0] r;
      if (v > X_W'(32767)) r = 16'sh7fff;
      else if (v < -X_W'(32768)) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction
endpackage
`default_nettype wire

>>> sv/rsi_if.sv
`default_nettype none
interface rsi_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [10:0]        address;
   logic signed [15:0] value;
   logic [4:0]         start_sample;
   modport source (output valid, command, address, value, start_sample, input ready);
   modport sink   (input valid, command, address, value, start_sample, output ready);
endinterface

interface rsi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] output_value;
   logic [1:0]         output_index;
   logic               last_output;
   modport source (output valid, output_value, output_index, last_output, input ready);
   modport sink   (input valid, output_value, output_index, last_output, output ready);
endinterface
`default_nettype wire

>>> sv/rsi_front.sv
`default_nettype none
module rsi_front import rsi_pkg::*; #(
   parameter int HIDDEN  = HIDDEN_DEF,
   parameter int INPUTS  = INPUTS_DEF,
   parameter int OUTPUTS = OUTPUTS_DEF,
   parameter int SAMPLES = SAMPLES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   rsi_req_if.sink  req,
   input  logic     pop,
   output head_type head
);
   localparam int WDEPTH = weight_depth(HIDDEN, INPUTS, OUTPUTS);
   localparam int SDEPTH = SAMPLES * INPUTS;
   localparam int QA_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QC_W   = $clog2(QDEPTH + 1);

   item_type          q_ff [QDEPTH];
   logic [QA_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QC_W-1:0]   cnt_ff, cnt_in;
   logic              keep, push;
   item_type          cls;
   logic [31:0]       addr32;

   // Drop unknown commands and loads aimed past their store.
   always_comb begin
      addr32           = {21'd0, req.address};
      cls.address      = req.address;
      cls.value        = req.value;
      cls.start_sample = req.start_sample;
      cls.kind         = KIND_RUN;
      keep             = 1'b0;
      case (req.command)
         CMD_WLOAD: begin
            cls.kind = KIND_WLOAD;
            keep     = addr32 < 32'(WDEPTH);
         end
         CMD_SLOAD: begin
            cls.kind = KIND_SLOAD;
            keep     = addr32 < 32'(SDEPTH);
         end
         CMD_RUN: begin
            cls.kind = KIND_RUN;
            keep     = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req.ready = cnt_ff != QC_W'(QDEPTH);
   assign push      = req.valid && req.ready && keep;
   assign head.vld  = cnt_ff != '0;
   assign head.item = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? QA_W'((32'(wr_ff) + 1) % QDEPTH) : wr_ff;
      rd_in  = pop  ? QA_W'((32'(rd_ff) + 1) % QDEPTH) : rd_ff;
      cnt_in = cnt_ff + QC_W'(push) - QC_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= cls;
   end
endmodule
`default_nettype wire

>>> sv/rsi_selu.sv
`default_nettype none
module rsi_selu import rsi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  selu_req_type sreq,
   output selu_rsp_type srsp
);
   localparam logic [30:0] Q30  = 31'h4000_0000;
   localparam logic [61:0] HALF = 62'h2000_0000;

   selu_state_type     st_ff, st_in;
   logic [25:0]        m_ff;
   logic [20:0]        m2_ff;
   logic [16:0]        m3_ff;
   logic [32:0]        q_ff;
   logic [30:0]        e_ff;
   logic [43:0]        dp_ff;
   logic [28:0]        mpos_ff;
   logic [2:0]         sq_ff;
   logic signed [15:0] y_ff;
   logic [X_W-1:0]     negx;
   logic [15:0]        xc;
   logic [51:0]        mm;
   logic [46:0]        mm3;
   logic [61:0]        sq;
   logic [30:0]        ec;
   logic [43:0]        dr;
   logic [28:0]        pr;

   always_comb begin
      negx = -sreq.x;
      xc   = (sreq.x > X_W'(32767)) ? 16'h7fff : sreq.x[15:0];
      mm   = 52'(m_ff) * 52'(m_ff);
      mm3  = 47'(m2_ff) * 47'(m_ff);
      sq   = 62'(e_ff) * 62'(e_ff) + HALF;
      ec   = (e_ff > Q30) ? Q30 : e_ff;
      dr   = dp_ff + 44'(HALF);
      pr   = mpos_ff + 29'd2048;
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         SE_IDLE: if (sreq.start) begin
            if (sreq.x > 0) st_in = SE_POS;
            else if (sreq.x < -X_W'(32768)) st_in = SE_DONE;
            else st_in = SE_M2;
         end
         SE_POS:  st_in = SE_DONE;
         SE_M2:   st_in = SE_M3;
         SE_M3:   st_in = SE_DIV;
         SE_DIV:  st_in = SE_SUM;
         SE_SUM:  st_in = SE_SQ;
         SE_SQ:   if (sq_ff == 3'd7) st_in = SE_FIN;
         SE_FIN:  st_in = SE_NEG;
         SE_NEG:  st_in = SE_DONE;
         SE_DONE: st_in = SE_IDLE;
         default: st_in = SE_IDLE;
      endcase
   end

   always_comb begin
      srsp.done = st_ff == SE_DONE;
      srsp.y    = y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= SE_IDLE;
      else st_ff <= st_in;
      case (st_ff)
         SE_IDLE: begin
            mpos_ff <= 29'(xc) * 29'd4304;
            m_ff    <= {negx[15:0], 10'd0};
            y_ff    <= -16'sd7201;
            sq_ff   <= '0;
         end
         SE_POS:  y_ff  <= (pr[28:12] > 17'd32767) ? 16'sh7fff : pr[27:12];
         SE_M2:   m2_ff <= mm[50:30];
         SE_M3:   m3_ff <= mm3[46:30];
         SE_DIV:  q_ff  <= 33'(m3_ff) * 33'd43691;
         SE_SUM:  e_ff  <= Q30 - 31'(m_ff) + 31'(m2_ff >> 1) - 31'(q_ff[32:18]);
         SE_SQ: begin
            e_ff  <= sq[60:30];
            sq_ff <= sq_ff + 3'd1;
         end
         SE_FIN:  dp_ff <= 44'(Q30 - ec) * 44'd7201;
         SE_NEG:  y_ff  <= -$signed({2'b00, dr[43:30]});
         default: ;
      endcase
   end
endmodule
`default_nettype wire

>>> sv/rsi_back.sv
`default_nettype none
module rsi_back import rsi_pkg::*; #(
   parameter int HIDDEN  = HIDDEN_DEF,
   parameter int INPUTS  = INPUTS_DEF,
   parameter int OUTPUTS = OUTPUTS_DEF,
   parameter int SAMPLES = SAMPLES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  head_type           head,
   output logic               pop,
   output selu_req_type       sreq,
   input  selu_rsp_type       srsp,
   input  logic               out_ready,
   output logic               out_valid,
   output logic signed [15:0] out_value,
   output logic [1:0]         out_index,
   output logic               out_last
);
   localparam int RW_BASE = INPUTS * HIDDEN;
   localparam int RB_BASE = RW_BASE + HIDDEN * HIDDEN;
   localparam int OW_BASE = RB_BASE + HIDDEN;
   localparam int OB_BASE = OW_BASE + HIDDEN * OUTPUTS;
   localparam int WDEPTH  = weight_depth(HIDDEN, INPUTS, OUTPUTS);
   localparam int SDEPTH  = SAMPLES * INPUTS;
   localparam int WA_W    = $clog2(WDEPTH);
   localparam int SA_W    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
   localparam int HID_AW  = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
   localparam int SMP_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int OUT_W   = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;
   localparam int TRM_W   = $clog2(INPUTS + HIDDEN + 1);

   logic signed [15:0] weight_mem_ff [WDEPTH];
   logic signed [15:0] sample_mem_ff [SDEPTH];
   logic signed [15:0] hidden_mem_ff [2 << HID_AW];

   back_state_type          st_ff, st_in;
   logic [4:0]              red_ff;
   logic [SMP_W-1:0]        s_ff, slot_ff;
   logic [SA_W-1:0]         sbase_ff;
   logic [HID_AW-1:0]       j_ff;
   logic [OUT_W-1:0]        o_ff;
   logic [TRM_W-1:0]        term_ff;
   logic [WA_W-1:0]         wptr_ff;
   logic                    cur_ff, outph_ff;
   logic                    p1_vld_ff, p2_vld_ff;
   src_type                 p1_src_ff;
   logic signed [15:0]      w_rd_ff, s_rd_ff, h_rd_ff;
   logic signed [31:0]      prod_ff;
   logic signed [ACC_W-1:0] acc_ff, accr;
   logic signed [X_W-1:0]   xr;
   logic                    out_vld_ff;
   logic signed [15:0]      out_val_ff;
   logic [1:0]              out_idx_ff;
   logic                    out_last_ff;

   logic                    issue, last_term, w_we, s_we, h_we, red_big, out_free;
   logic                    last_j, last_s, last_o;
   src_type                 src;
   logic [WA_W-1:0]         wa;
   logic [SA_W-1:0]         sa;
   logic [HID_AW-1:0]       hidx;
   logic signed [15:0]      a_op;
   logic [31:0]             addr32;

   always_comb begin
      addr32    = {21'd0, head.item.address};
      red_big   = {27'd0, red_ff} >= 32'(SAMPLES);
      last_term = term_ff == TRM_W'(outph_ff ? HIDDEN : INPUTS + HIDDEN);
      last_j    = j_ff == HID_AW'(HIDDEN - 1);
      last_s    = s_ff == SMP_W'(SAMPLES - 1);
      last_o    = o_ff == OUT_W'(OUTPUTS - 1);
      out_free  = !out_vld_ff || out_ready;
      accr      = acc_ff + ACC_W'(2048);
      xr        = accr[ACC_W-1:12];
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         BK_IDLE:  if (head.vld && head.item.kind == KIND_RUN) st_in = BK_PREP;
         BK_PREP:  if (!red_big) st_in = BK_MAC;
         BK_MAC:   if (last_term) st_in = BK_DRAIN;
         BK_DRAIN: if (!p1_vld_ff && !p2_vld_ff) st_in = outph_ff ? BK_OUT : BK_ACT;
         BK_ACT:   if (srsp.done) st_in = BK_MAC;
         BK_OUT:   if (out_free) st_in = last_o ? BK_IDLE : BK_MAC;
         default:  st_in = BK_IDLE;
      endcase
   end

   // Term sequencer: input terms, then recurrent terms, then the bias; in the output phase, hidden terms then the bias.
   always_comb begin
      pop  = 1'b0;
      w_we = 1'b0;
      s_we = 1'b0;
      h_we = 1'b0;
      issue = 1'b0;
      src  = SRC_ZERO;
      wa   = wptr_ff;
      sa   = SA_W'(32'(sbase_ff) + 32'(term_ff));
      hidx = HID_AW'(term_ff);
      sreq.start = 1'b0;
      sreq.x     = xr;
      case (st_ff)
         BK_IDLE: begin
            pop  = head.vld;
            w_we = head.vld && head.item.kind == KIND_WLOAD;
            s_we = head.vld && head.item.kind == KIND_SLOAD;
            wa   = addr32[WA_W-1:0];
            sa   = addr32[SA_W-1:0];
         end
         BK_MAC: begin
            issue = 1'b1;
            if (!outph_ff) begin
               hidx = HID_AW'(32'(term_ff) - INPUTS);
               if (32'(term_ff) < INPUTS) src = SRC_SMP;
               else if (!last_term) src = (s_ff == '0) ? SRC_ZERO : SRC_HID;
               else begin
                  src = SRC_BIAS;
                  wa  = WA_W'(RB_BASE + 32'(j_ff));
               end
            end else if (!last_term) src = SRC_HID;
            else begin
               src = SRC_BIAS;
               wa  = WA_W'(OB_BASE + 32'(o_ff));
            end
         end
         BK_DRAIN: sreq.start = !p1_vld_ff && !p2_vld_ff && !outph_ff;
         BK_ACT:   h_we = srsp.done;
         default: ;
      endcase
   end

   always_comb begin
      case (p1_src_ff)
         SRC_SMP:  a_op = s_rd_ff;
         SRC_HID:  a_op = h_rd_ff;
         SRC_BIAS: a_op = 16'sd4096;
         default:  a_op = 16'sd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (w_we) weight_mem_ff[wa] <= head.item.value;
      w_rd_ff <= weight_mem_ff[wa];
   end

   always_ff @(posedge clock) begin
      if (s_we) sample_mem_ff[sa] <= head.item.value;
      s_rd_ff <= sample_mem_ff[sa];
   end

   always_ff @(posedge clock) begin
      if (h_we) hidden_mem_ff[{!cur_ff, j_ff}] <= srsp.y;
      h_rd_ff <= hidden_mem_ff[{cur_ff, hidx}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= BK_IDLE;
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         p1_vld_ff <= issue;
         p2_vld_ff <= p1_vld_ff;
         if (st_ff == BK_OUT && out_free) out_vld_ff <= 1'b1;
         else if (out_ready) out_vld_ff <= 1'b0;
      end
      p1_src_ff <= src;
      prod_ff   <= a_op * w_rd_ff;
      if (p2_vld_ff) acc_ff <= acc_ff + ACC_W'(prod_ff);
      if (issue) begin
         term_ff <= term_ff + TRM_W'(1);
         wptr_ff <= wptr_ff + WA_W'(outph_ff ? OUTPUTS : HIDDEN);
      end
      case (st_ff)
         BK_IDLE: red_ff <= head.item.start_sample;
         BK_PREP: begin
            if (red_big) red_ff <= red_ff - 5'(SAMPLES);
            slot_ff  <= SMP_W'({27'd0, red_ff});
            sbase_ff <= SA_W'(32'(red_ff) * INPUTS);
            s_ff     <= '0;
            j_ff     <= '0;
            o_ff     <= '0;
            cur_ff   <= 1'b0;
            outph_ff <= 1'b0;
            term_ff  <= '0;
            wptr_ff  <= '0;
            acc_ff   <= '0;
         end
         BK_ACT: if (srsp.done) begin
            term_ff <= '0;
            acc_ff  <= '0;
            if (!last_j) begin
               j_ff    <= j_ff + HID_AW'(1);
               wptr_ff <= WA_W'(32'(j_ff) + 1);
            end else begin
               j_ff   <= '0;
               cur_ff <= !cur_ff;
               if (last_s) begin
                  outph_ff <= 1'b1;
                  wptr_ff  <= WA_W'(OW_BASE);
               end else begin
                  s_ff     <= s_ff + SMP_W'(1);
                  wptr_ff  <= '0;
                  slot_ff  <= (slot_ff == SMP_W'(SAMPLES - 1)) ? '0 : slot_ff + SMP_W'(1);
                  sbase_ff <= (slot_ff == SMP_W'(SAMPLES - 1)) ? '0
                              : SA_W'(32'(sbase_ff) + INPUTS);
               end
            end
         end
         BK_OUT: if (out_free) begin
            out_val_ff  <= sat16(xr);
            out_idx_ff  <= 2'(32'(o_ff));
            out_last_ff <= last_o;
            o_ff        <= o_ff + OUT_W'(1);
            wptr_ff     <= WA_W'(OW_BASE + 32'(o_ff) + 1);
            term_ff     <= '0;
            acc_ff      <= '0;
         end
         default: ;
      endcase
   end

   assign out_valid = out_vld_ff;
   assign out_value = out_val_ff;
   assign out_index = out_idx_ff;
   assign out_last  = out_last_ff;
endmodule
`default_nettype wire

>>> sv/rnn_sequence_inference_top.sv
// Elman recurrent network inference engine with a SELU hidden layer and a
// linear output layer, all in signed Q4.12 with wide accumulation.
// The req channel carries one word per command: load a weight word, load a
// sample feature into the ring store, or start a run at a ring position.
// The rsp channel returns OUTPUTS words per run, the final one flagged by
// last_output. Loads produce no words; unknown commands and loads beyond a
// store are accepted and dropped.
// A two-entry queue separates the accepting front from the executing back,
// so loads are taken at one per cycle until the queue fills behind a run.
// A run is executed by one shared multiply-accumulate unit fed from the
// weight, sample and hidden memories, once the start position has been
// folded into the ring. Each hidden activation runs through the iterative
// SELU unit.
// Results sit in an output register; while the receiver stalls it holds the
// word and the back end waits before producing the next one.
// Synchronous reset empties the queue and the output register and returns the
// sequencer to idle; memory contents are not cleared.
`default_nettype none
module rnn_sequence_inference_top import rsi_pkg::*; #(
   parameter int HIDDEN  = HIDDEN_DEF,
   parameter int INPUTS  = INPUTS_DEF,
   parameter int OUTPUTS = OUTPUTS_DEF,
   parameter int SAMPLES = SAMPLES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rsi_req_if.sink    req_port,
   rsi_rsp_if.source  rsp_port
);
   head_type     head;
   logic         pop;
   selu_req_type sreq;
   selu_rsp_type srsp;

   // Front end: classify and queue incoming words.
   rsi_front #(
      .HIDDEN(HIDDEN), .INPUTS(INPUTS), .OUTPUTS(OUTPUTS), .SAMPLES(SAMPLES)
   ) u_front (
      .clock(clock), .reset(reset), .req(req_port), .pop(pop), .head(head)
   );

   // Shared activation unit used once per hidden neuron per sample.
   rsi_selu u_selu (
      .clock(clock), .reset(reset), .sreq(sreq), .srsp(srsp)
   );

   // Back end: memories, term sequencer, accumulator and result register.
   rsi_back #(
      .HIDDEN(HIDDEN), .INPUTS(INPUTS), .OUTPUTS(OUTPUTS), .SAMPLES(SAMPLES)
   ) u_back (
      .clock(clock), .reset(reset), .head(head), .pop(pop),
      .sreq(sreq), .srsp(srsp),
      .out_ready(rsp_port.ready), .out_valid(rsp_port.valid),
      .out_value(rsp_port.output_value), .out_index(rsp_port.output_index),
      .out_last(rsp_port.last_output)
   );
endmodule
`default_nettype wire

>>> sv/rsi_checker.sv
`default_nettype none
`include "rnn_sequence_inference_top_assert.svh"
module rsi_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_output_value,
   input wire logic [1:0]  rsp_output_index,
   input wire logic        rsp_last_output
);
   `RSI_ASSERT_NEXT(a_hold_valid, rsp_valid && !rsp_ready, rsp_valid)
   `RSI_ASSERT_NEXT(a_hold_data, rsp_valid && !rsp_ready, $stable({rsp_output_value, rsp_output_index, rsp_last_output}))
   `RSI_ASSERT_RST(a_reset_idle, reset, !rsp_valid)
   `RSI_ASSERT_NEXT(a_gap_after_last, rsp_valid && rsp_ready && rsp_last_output, !rsp_valid)
endmodule

bind rnn_sequence_inference_top rsi_checker u_rsi_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_port.valid), .rsp_ready(rsp_port.ready),
   .rsp_output_value(rsp_port.output_value),
   .rsp_output_index(rsp_port.output_index),
   .rsp_last_output(rsp_port.last_output)
);
`default_nettype wire
